/* design/ncdf_pkg.sv */
// Package for the normal CDF pipeline: formats, coefficients and the item record.
// Used by normal_cdf_polynomial; no dependencies of its own.
package ncdf_pkg;

	localparam int IN_FRAC_BITS_DEF  = 16;
	localparam int OUT_FRAC_BITS_DEF = 32;

	localparam int X_W        = 23;   // x_value field
	localparam int PROB_W     = 32;   // probability field
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 32;

	localparam int FAR_INT    = 10;   // |x| at or above this gives zero tail
	localparam int A_W        = 28;   // |x| in Q24 below the far limit
	localparam int PROD_W     = 66;
	localparam int DEN_W      = 34;
	localparam int REM_W      = 35;
	localparam int T_W        = 31;   // t in Q30, up to 1.0
	localparam int ACC_W      = 36;
	localparam int POLY_W     = 34;
	localparam int TERM_W     = 32;
	localparam int EXPV_W     = 33;   // exp value, up to 1.0 in Q32
	localparam int WHOLE_W    = 6;

	localparam int DIV_STEPS  = T_W;
	localparam int HOR_STEPS  = 5;
	localparam int SER_DEG    = 14;
	localparam int POW_STEPS  = FAR_INT * FAR_INT / 2 - 1;

	localparam logic [63:0] COEF_P  = ((64'd2316419 << 32) + 64'd5000000) / 64'd10000000;
	localparam logic [63:0] COEF_B1 = ((64'd319381530 << 32) + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] COEF_B2 = ((64'd356563782 << 32) + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] COEF_B3 = ((64'd1781477937 << 32) + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] COEF_B4 = ((64'd1821255978 << 32) + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] COEF_B5 = ((64'd1330274429 << 32) + 64'd500000000) / 64'd1000000000;
	localparam logic [31:0] INV_SQRT_2PI = 32'd1713444047;

	typedef logic signed [ACC_W-1:0] acc_t;

	// Horner coefficient added after each multiply by t
	localparam acc_t HOR_COEF [HOR_STEPS] = '{
		-acc_t'(COEF_B4), acc_t'(COEF_B3), -acc_t'(COEF_B2), acc_t'(COEF_B1), acc_t'(0)
	};

	// exp(-1) as the square of the truncated series at one half, Q32
	function automatic logic [31:0] exp_neg_one();
		logic [63:0] s;
		logic [63:0] tm;
		logic [63:0] sq;
		s  = 64'd1 << 32;
		tm = s;
		for (int k = 1; k <= SER_DEG; k++) begin
			tm = ((tm * 64'd2147483648) >> 32) / 64'(k);
			if (k % 2 == 1)
				s = s - tm;
			else
				s = s + tm;
		end
		sq = (s * s) >> 32;
		return sq[31:0];
	endfunction

	localparam logic [31:0] E1 = exp_neg_one();

	typedef struct packed {
		logic                 neg;
		logic                 far;
		logic [A_W-1:0]       a24;
		logic [PROD_W-1:0]    pa;
		logic [PROD_W-1:0]    pb;
		logic [DEN_W-1:0]     den;
		logic [REM_W-1:0]     rem;
		logic [T_W-1:0]       tq;
		acc_t                 acc;
		logic [31:0]          frac;
		logic [WHOLE_W-1:0]   whole;
		logic [TERM_W-1:0]    term;
		logic [EXPV_W-1:0]    expv;
		logic [31:0]          scaled;
		logic [31:0]          tail;
		logic [PROB_W-1:0]    prob;
	} ncdf_item_t;

endpackage

/* design/normal_cdf_polynomial.sv */
// Throughput one item per cycle while the skid is empty; input stalls while the skid holds a result.
// Critical stages: 31-stage restoring divider for t, 39-stage Taylor series for exp(-r),
// and 49 conditional multiplies by exp(-1), all in one pipeline of 135 registers.
// A one-entry skid after the output register lets the pipeline advance while a result waits, until the skid fills.
// arst_n clears all valid bits and the output/skid flags; payload registers are not reset.
// Depends on ncdf_pkg.
module normal_cdf_polynomial #(
	parameter int IN_FRAC_BITS  = ncdf_pkg::IN_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = ncdf_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ncdf_pkg::S_TDATA_W-1:0] s_tdata,   // [22:0] x_value, [23] zero
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ncdf_pkg::M_TDATA_W-1:0] m_tdata    // [31:0] probability
);
	import ncdf_pkg::*;

	localparam int ST_MUL     = 1;
	localparam int ST_DEN     = 2;
	localparam int ST_DIV0    = 3;
	localparam int ST_HOR0    = ST_DIV0 + DIV_STEPS;
	localparam int ST_SER0    = ST_HOR0 + 2 * HOR_STEPS;
	localparam int ST_POW0    = ST_SER0 + 3 * (SER_DEG - 1);
	localparam int ST_SCL     = ST_POW0 + POW_STEPS;
	localparam int ST_TAIL    = ST_SCL + 1;
	localparam int ST_OUT     = ST_TAIL + 1;
	localparam int NUM_STAGES = ST_OUT + 1;

	localparam int A_SH   = 24 - IN_FRAC_BITS;
	localparam int OW     = ((OUT_FRAC_BITS > 32) ? OUT_FRAC_BITS : 32) + 2;
	localparam int RND_SH = (OUT_FRAC_BITS < 32) ? 32 - OUT_FRAC_BITS : 1;
	localparam int LFT_SH = (OUT_FRAC_BITS > 32) ? OUT_FRAC_BITS - 32 : 0;
	localparam logic [OW-1:0] ONE_O = OW'(1) << OUT_FRAC_BITS;
	localparam logic [OW-1:0] MAXC  = (OUT_FRAC_BITS >= PROB_W) ?
		OW'({PROB_W{1'b1}}) : ONE_O - OW'(1);

	ncdf_item_t            pipe_s [NUM_STAGES];
	logic [NUM_STAGES-1:0] vld_s;
	logic                  en;

	logic                  out_vld_q;
	logic [PROB_W-1:0]     out_q;
	logic                  skid_vld_q;
	logic [PROB_W-1:0]     skid_q;

	assign en = !skid_vld_q;

	// ---- stage 0: magnitude, far flag, Q24 alignment
	ncdf_item_t        in_nxt;
	logic [X_W-1:0]    x_in;
	logic [X_W-1:0]    mag_in;
	logic [46:0]       mag_wide;
	logic [46:0]       a_shift;

	always_comb begin
		x_in     = s_tdata[X_W-1:0];
		mag_in   = x_in[X_W-1] ? (~x_in + X_W'(1)) : x_in;
		mag_wide = {24'b0, mag_in};
		a_shift  = mag_wide << A_SH;
		in_nxt     = '0;
		in_nxt.neg = x_in[X_W-1];
		in_nxt.far = (mag_wide >= (47'(FAR_INT) << IN_FRAC_BITS));
		in_nxt.a24 = a_shift[A_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en)
			pipe_s[0] <= in_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NUM_STAGES-2:0], s_tvalid};
		end
	end

	// ---- pipeline stages
	for (genvar i = 1; i < NUM_STAGES; i++) begin : g_stage
		ncdf_item_t nxt;

		if (i == ST_MUL) begin : g_mul
			always_comb begin
				nxt    = pipe_s[i-1];
				nxt.pa = PROD_W'({38'b0, nxt.a24} * {2'b0, COEF_P[63:0]});
				nxt.pb = PROD_W'({38'b0, nxt.a24} * {38'b0, nxt.a24});
			end
		end else if (i == ST_DEN) begin : g_den
			always_comb begin
				nxt       = pipe_s[i-1];
				nxt.den   = (DEN_W'(1) << 32) + nxt.pa[57:24];
				nxt.frac  = nxt.pb[48:17];
				nxt.whole = nxt.pb[54:49];
				nxt.rem   = REM_W'(1) << 31;
				nxt.tq    = '0;
				nxt.acc   = acc_t'(COEF_B5);
				nxt.term  = nxt.pb[48:17];
				nxt.expv  = (EXPV_W'(1) << 32) - {1'b0, nxt.pb[48:17]};
			end
		end else if (i < ST_HOR0) begin : g_div
			// one quotient bit of 2^62 / den
			always_comb begin
				logic [REM_W-1:0] r2;
				nxt = pipe_s[i-1];
				r2  = {nxt.rem[REM_W-2:0], 1'b0};
				if (r2 >= {1'b0, nxt.den}) begin
					nxt.rem = r2 - {1'b0, nxt.den};
					nxt.tq  = {nxt.tq[T_W-2:0], 1'b1};
				end else begin
					nxt.rem = r2;
					nxt.tq  = {nxt.tq[T_W-2:0], 1'b0};
				end
			end
		end else if (i < ST_SER0) begin : g_hor
			localparam int HJ = (i - ST_HOR0) / 2;
			localparam int HP = (i - ST_HOR0) % 2;
			if (HP == 0) begin : g_mul_t
				// |acc| split in two halves, each times t
				always_comb begin
					logic [ACC_W-1:0] mag;
					nxt = pipe_s[i-1];
					mag = nxt.acc[ACC_W-1] ? ACC_W'(-nxt.acc) : ACC_W'(nxt.acc);
					nxt.pa = {48'b0, mag[17:0]} * {35'b0, nxt.tq};
					nxt.pb = {48'b0, mag[ACC_W-1:18]} * {35'b0, nxt.tq};
				end
			end else begin : g_add
				always_comb begin
					logic [PROD_W:0] ps;
					acc_t            prod;
					nxt  = pipe_s[i-1];
					ps   = ((PROD_W+1)'(nxt.pb) << 18) + (PROD_W+1)'(nxt.pa);
					prod = acc_t'(ps[65:30]);
					nxt.acc = HOR_COEF[HJ] + (nxt.acc[ACC_W-1] ? -prod : prod);
				end
			end
		end else if (i < ST_POW0) begin : g_ser
			localparam int SK = (i - ST_SER0) / 3 + 2;
			localparam int SP = (i - ST_SER0) % 3;
			localparam logic [31:0] SER_M = 32'((64'd1 << 32) / SK);
			localparam logic [33:0] SER_KW = 34'(SK);
			if (SP == 0) begin : g_tr
				always_comb begin
					nxt    = pipe_s[i-1];
					nxt.pa = PROD_W'({32'b0, nxt.term} * {32'b0, nxt.frac});
				end
			end else if (SP == 1) begin : g_rcp
				// estimate of floor(n / k), low by at most one
				always_comb begin
					nxt    = pipe_s[i-1];
					nxt.pb = PROD_W'({32'b0, nxt.pa[63:32]} * {32'b0, SER_M});
				end
			end else begin : g_fix
				always_comb begin
					logic [33:0] rm;
					logic [31:0] qe;
					logic [31:0] q;
					nxt = pipe_s[i-1];
					qe  = nxt.pb[63:32];
					rm  = {2'b0, nxt.pa[63:32]} - 34'({2'b0, qe} * SER_KW);
					q   = (rm >= SER_KW) ? qe + 32'd1 : qe;
					nxt.term = q;
					if (SK % 2 == 1)
						nxt.expv = nxt.expv - {1'b0, q};
					else
						nxt.expv = nxt.expv + {1'b0, q};
				end
			end
		end else if (i < ST_SCL) begin : g_pow
			localparam logic [WHOLE_W-1:0] PIDX = WHOLE_W'(i - ST_POW0);
			always_comb begin
				logic [64:0] pw;
				nxt = pipe_s[i-1];
				pw  = {32'b0, nxt.expv} * {33'b0, E1};
				if (nxt.whole > PIDX)
					nxt.expv = pw[64:32];
			end
		end else if (i == ST_SCL) begin : g_scl
			always_comb begin
				logic [POLY_W-1:0] poly;
				logic [65:0]       sp;
				nxt  = pipe_s[i-1];
				poly = nxt.acc[ACC_W-1] ? '0 : nxt.acc[POLY_W-1:0];
				sp   = {32'b0, poly} * {34'b0, INV_SQRT_2PI};
				nxt.scaled = sp[63:32];
			end
		end else if (i == ST_TAIL) begin : g_tail
			always_comb begin
				logic [64:0] tp;
				nxt = pipe_s[i-1];
				tp  = {33'b0, nxt.scaled} * {32'b0, nxt.expv};
				nxt.tail = nxt.far ? '0 : tp[63:32];
			end
		end else begin : g_out
			always_comb begin
				logic [OW-1:0] to;
				logic [OW-1:0] pr;
				nxt = pipe_s[i-1];
				if (OUT_FRAC_BITS < 32)
					to = (OW'(nxt.tail) + (OW'(1) << (RND_SH - 1))) >> RND_SH;
				else
					to = OW'(nxt.tail) << LFT_SH;
				if (nxt.neg)
					pr = to;
				else
					pr = (to > ONE_O) ? '0 : ONE_O - to;
				if (pr > MAXC)
					pr = MAXC;
				nxt.prob = pr[PROB_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en)
				pipe_s[i] <= nxt;
		end
	end

	// ---- output register with one-entry skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= vld_s[ST_OUT];
			end
		end else if (vld_s[ST_OUT] && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready)
			out_q <= skid_vld_q ? skid_q : pipe_s[ST_OUT].prob;
		if (out_vld_q && !m_tready && en)
			skid_q <= pipe_s[ST_OUT].prob;
	end

	assign s_tready = en;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds an item while output register is empty");

	a_skid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(vld_s[ST_OUT]) && $past(out_vld_q) && !$past(m_tready))
		else $error("skid filled without a stalled result and a new item");

	a_div_result: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_HOR0-1] && !pipe_s[ST_HOR0-1].far |->
			pipe_s[ST_HOR0-1].rem < {1'b0, pipe_s[ST_HOR0-1].den} &&
			pipe_s[ST_HOR0-1].tq <= (T_W'(1) << 30))
		else $error("divider remainder or quotient out of range");

	a_far_result: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_OUT] && pipe_s[ST_OUT].far |->
			pipe_s[ST_OUT].prob == (pipe_s[ST_OUT].neg ? '0 : MAXC[PROB_W-1:0]))
		else $error("far argument did not give a saturated probability");
`endif

endmodule

/* verif/normal_cdf_polynomial_tb.sv */
// Testbench for normal_cdf_polynomial: streams x samples and checks each Phi(x) bit for bit.
// The expected probability comes from a fixed-point predictor built into the bench.
// Depends on ncdf_pkg and normal_cdf_polynomial.
module normal_cdf_polynomial_tb;
	import ncdf_pkg::*;

	localparam int LATENCY = 135;
	localparam logic [63:0] ONE_Q32 = 64'd1 << 32;
	localparam int FAR_CODE = 10 << 16;   // 10.0 with 16 fraction bits

	typedef struct {
		logic [X_W-1:0]    x;
		logic [PROB_W-1:0] prob;
	} cdf_expect_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	cdf_expect_t pending_probs[$];
	int          mismatch_count;
	bit          calm_mode;    // no idling on either side
	int          hold_request;
	int          hold_left;

	normal_cdf_polynomial dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// exp(-r), 0 <= r < 1, degree-14 Taylor series in Q32
	function automatic logic [63:0] exp_frac(input logic [63:0] r);
		logic [63:0] sum;
		logic [63:0] term;
		sum  = ONE_Q32;
		term = ONE_Q32;
		for (int k = 1; k <= 14; k++) begin
			term = ((term * r) >> 32) / 64'(k);
			if (k % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		return sum;
	endfunction

	// signed Q32 times unsigned Q30 t, truncated toward zero
	function automatic longint times_t(input longint acc, input logic [63:0] tq);
		logic [63:0] mag;
		logic [63:0] prod;
		mag  = (acc < 0) ? 64'(-acc) : 64'(acc);
		prod = (mag * tq) >> 30;
		return (acc < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	function automatic logic [PROB_W-1:0] normal_cdf(input logic [X_W-1:0] x);
		logic        neg;
		logic [63:0] mag, a24, den, tq, poly, yq, expv, e1, half, scaled, tail, prob;
		longint      acc;
		neg  = x[X_W-1];
		mag  = neg ? (64'd1 << X_W) - 64'(x) : 64'(x);
		tail = 0;
		if (mag < 64'(FAR_CODE)) begin
			a24 = mag << 8;
			den = ONE_Q32 + ((COEF_P * a24) >> 24);
			tq  = (64'd1 << 62) / den;
			acc = longint'(COEF_B5);
			acc = -longint'(COEF_B4) + times_t(acc, tq);
			acc =  longint'(COEF_B3) + times_t(acc, tq);
			acc = -longint'(COEF_B2) + times_t(acc, tq);
			acc =  longint'(COEF_B1) + times_t(acc, tq);
			acc = times_t(acc, tq);
			poly = (acc < 0) ? 64'd0 : 64'(acc);
			yq   = (a24 * a24) >> 17;
			half = exp_frac(ONE_Q32 >> 1);
			e1   = (half * half) >> 32;
			expv = exp_frac({32'd0, yq[31:0]});
			for (int m = 0; m < int'(yq >> 32) && m < 64; m++)
				expv = (expv * e1) >> 32;
			scaled = (poly * 64'(INV_SQRT_2PI)) >> 32;
			tail   = (scaled * expv) >> 32;
		end
		if (neg)
			prob = tail;
		else
			prob = (tail > ONE_Q32) ? 64'd0 : ONE_Q32 - tail;
		if (prob > 64'hFFFF_FFFF)
			prob = 64'hFFFF_FFFF;
		return prob[31:0];
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input logic [X_W-1:0] x, input logic [PROB_W-1:0] want,
			input logic [PROB_W-1:0] got);
		$display("MISMATCH x=%0d (0x%06h): probability expected 0x%08h got 0x%08h",
			$signed(x), x, want, got);
		mismatch_count++;
	endtask

	// offers one item, waits for acceptance, then idles at random
	task automatic send_sample(input logic [X_W-1:0] x);
		int gap;
		cdf_expect_t e;
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		e.x    = x;
		e.prob = normal_cdf(x);
		pending_probs.push_back(e);
		gap = calm_mode ? 0 : idle_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// receiver: random stalls, a counted long hold when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
		end else if (hold_request > 0) begin
			hold_left    <= hold_request - 1;
			hold_request = 0;
			m_tready     <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (calm_mode) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 99) == 0)
				hold_left <= $urandom_range(8, 40);
		end
	end

	always @(posedge clk) begin
		cdf_expect_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_probs.size() == 0) begin
				$display("UNEXPECTED result 0x%08h with nothing pending", m_tdata);
				mismatch_count++;
			end else begin
				e = pending_probs.pop_front();
				if (m_tdata[PROB_W-1:0] !== e.prob)
					report_mismatch(e.x, e.prob, m_tdata[PROB_W-1:0]);
			end
		end
	end

	task automatic test_directed();
		int pts[$];
		pts = '{0, 1, -1, 4194303, -4194304, FAR_CODE, -FAR_CODE, FAR_CODE - 1,
			-(FAR_CODE - 1), FAR_CODE + 1, -(FAR_CODE + 1), 65536, -65536, 32768,
			-32768, 131072, -131072, 5 * 65536, -5 * 65536, 8 * 65536 + 12345,
			-8 * 65536 - 12345, 2097152, -2097152};
		foreach (pts[i])
			send_sample(pts[i][X_W-1:0]);
	endtask

	// mostly inside the far limit, where the polynomial path does the work, up to 32 codes past it on each side
	task automatic test_random_core(input int n);
		int v;
		for (int i = 0; i < n; i++) begin
			v = int'($urandom_range(0, 2 * FAR_CODE + 64)) - FAR_CODE - 32;
			send_sample(v[X_W-1:0]);
		end
	endtask

	task automatic test_random_full(input int n);
		for (int i = 0; i < n; i++)
			send_sample(23'($urandom()));
	endtask

	task automatic test_full_rate(input int n);
		calm_mode = 1'b1;
		test_random_core(n);
		calm_mode = 1'b0;
	endtask

	// receiver holds off long enough for the pipeline and skid to fill
	task automatic test_backpressure(input int n);
		calm_mode    = 1'b1;
		hold_request = 3 * LATENCY;
		test_random_core(n);
		calm_mode = 1'b0;
	endtask

	initial begin
		mismatch_count = 0;
		calm_mode      = 1'b0;
		hold_request   = 0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_core(950);
		test_random_full(300);
		test_full_rate(200);
		test_backpressure(250);
		s_tvalid <= 1'b0;
		while (pending_probs.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
